FILE: sv/quaternion_vector_rotator_defines.svh
// ---------------------------------------------------------------------------
// quaternion_vector_rotator_defines.svh
// Assertion macros shared by the rotator RTL. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATOR_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on aclk, idle while aresetn is low.
`define QVR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on aclk at every edge, reset included.
`define QVR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define QVR_ASSERT(label, prop, msg)
`define QVR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: sv/qvr_pkg.sv
// ---------------------------------------------------------------------------
// qvr_pkg
// Types, widths and helpers for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_W   = 16;   // Q2.14
    localparam int POS_W    = 24;   // 8 fraction bits
    localparam int PROD1_W  = QUAT_W + POS_W;        // q * v product
    localparam int T_W      = PROD1_W + 1;           // sum of three products
    localparam int PROD2_W  = T_W + QUAT_W;          // t * q product
    localparam int S_W      = PROD2_W + 2;           // sum of four products
    localparam int RSUM_W   = S_W + 1;               // room for rounding add
    localparam int RND_SHIFT = 28;                   // 36 -> 8 fraction bits
    localparam int RND_W    = RSUM_W - RND_SHIFT;
    localparam int STAGES   = 5;

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [PROD1_W-1:0] prod1_t;
    typedef logic signed [T_W-1:0]     tval_t;
    typedef logic signed [PROD2_W-1:0] prod2_t;
    typedef logic signed [S_W-1:0]     sval_t;
    typedef logic signed [RSUM_W-1:0]  rsum_t;
    typedef logic signed [RND_W-1:0]   rnd_t;

    localparam rsum_t RND_HALF = rsum_t'(64'd1 << (RND_SHIFT - 1));
    localparam pos_t  POS_MAX  = pos_t'({1'b0, {(POS_W-1){1'b1}}});
    localparam pos_t  POS_MIN  = pos_t'({1'b1, {(POS_W-1){1'b0}}});

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] rot_x;
        logic signed [POS_W-1:0] rot_y;
        logic signed [POS_W-1:0] rot_z;
        logic                    saturated;
    } out_beat_t;

    // Pipeline control from the handshake logic.
    typedef struct packed {
        logic advance;   // every stage moves one step
        logic in_valid;  // beat offered at the input
    } pipe_ctrl_t;

    // Round to nearest (ties up) and drop 28 fraction bits.
    function automatic rnd_t round_s(input sval_t s);
        rsum_t sum;
        sum = rsum_t'(s) + RND_HALF;
        return rnd_t'(sum >>> RND_SHIFT);
    endfunction

    // Clamp to the position range; bit POS_W of the result flags a clamp.
    function automatic logic [POS_W:0] clamp_pos(input rnd_t r);
        logic hi;
        logic lo;
        hi = !r[RND_W-1] && (r[RND_W-2:POS_W-1] != '0);
        lo =  r[RND_W-1] && (r[RND_W-2:POS_W-1] != '1);
        if (hi) begin
            return {1'b1, POS_MAX};
        end else if (lo) begin
            return {1'b1, POS_MIN};
        end
        return {1'b0, r[POS_W-1:0]};
    endfunction

endpackage

FILE: sv/qvr_datapath.sv
// ---------------------------------------------------------------------------
// qvr_datapath
// Five-stage pipeline: q*v products, t sums, t*conj(q) products,
// s sums, round/saturate into the output register.
// ---------------------------------------------------------------------------
`include "quaternion_vector_rotator_defines.svh"

module qvr_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qvr_pkg::pipe_ctrl_t  ctrl,
    input  qvr_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    output qvr_pkg::out_beat_t   out_data
);

    logic [qvr_pkg::STAGES-1:0] vld_reg;
    logic [qvr_pkg::STAGES-1:0] vld_next;

    // stage 1: q * v
    qvr_pkg::quat_t  q1x_reg, q1y_reg, q1z_reg, q1w_reg;
    qvr_pkg::prod1_t a_xx_reg, a_yy_reg, a_zz_reg;   // tw
    qvr_pkg::prod1_t a_wx_reg, a_yz_reg, a_zy_reg;   // tx
    qvr_pkg::prod1_t a_wy_reg, a_zx_reg, a_xz_reg;   // ty
    qvr_pkg::prod1_t a_wz_reg, a_xy_reg, a_yx_reg;   // tz

    // stage 2: t = q * (v, 0)
    qvr_pkg::quat_t q2x_reg, q2y_reg, q2z_reg, q2w_reg;
    qvr_pkg::tval_t tw_reg, tx_reg, ty_reg, tz_reg;
    qvr_pkg::tval_t tw_next, tx_next, ty_next, tz_next;

    // stage 3: t * conj(q)
    qvr_pkg::prod2_t bx0_reg, bx1_reg, bx2_reg, bx3_reg;
    qvr_pkg::prod2_t by0_reg, by1_reg, by2_reg, by3_reg;
    qvr_pkg::prod2_t bz0_reg, bz1_reg, bz2_reg, bz3_reg;

    // stage 4: vector part
    qvr_pkg::sval_t sx_reg, sy_reg, sz_reg;
    qvr_pkg::sval_t sx_next, sy_next, sz_next;

    // stage 5: rounded, saturated
    qvr_pkg::out_beat_t out_reg;
    qvr_pkg::out_beat_t out_next;
    logic [qvr_pkg::POS_W:0] cx, cy, cz;

    assign vld_next = {vld_reg[qvr_pkg::STAGES-2:0], ctrl.in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.advance) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            q1x_reg  <= in_data.quat_x;
            q1y_reg  <= in_data.quat_y;
            q1z_reg  <= in_data.quat_z;
            q1w_reg  <= in_data.quat_w;
            a_xx_reg <= qvr_pkg::prod1_t'(in_data.quat_x) * qvr_pkg::prod1_t'(in_data.pos_x);
            a_yy_reg <= qvr_pkg::prod1_t'(in_data.quat_y) * qvr_pkg::prod1_t'(in_data.pos_y);
            a_zz_reg <= qvr_pkg::prod1_t'(in_data.quat_z) * qvr_pkg::prod1_t'(in_data.pos_z);
            a_wx_reg <= qvr_pkg::prod1_t'(in_data.quat_w) * qvr_pkg::prod1_t'(in_data.pos_x);
            a_yz_reg <= qvr_pkg::prod1_t'(in_data.quat_y) * qvr_pkg::prod1_t'(in_data.pos_z);
            a_zy_reg <= qvr_pkg::prod1_t'(in_data.quat_z) * qvr_pkg::prod1_t'(in_data.pos_y);
            a_wy_reg <= qvr_pkg::prod1_t'(in_data.quat_w) * qvr_pkg::prod1_t'(in_data.pos_y);
            a_zx_reg <= qvr_pkg::prod1_t'(in_data.quat_z) * qvr_pkg::prod1_t'(in_data.pos_x);
            a_xz_reg <= qvr_pkg::prod1_t'(in_data.quat_x) * qvr_pkg::prod1_t'(in_data.pos_z);
            a_wz_reg <= qvr_pkg::prod1_t'(in_data.quat_w) * qvr_pkg::prod1_t'(in_data.pos_z);
            a_xy_reg <= qvr_pkg::prod1_t'(in_data.quat_x) * qvr_pkg::prod1_t'(in_data.pos_y);
            a_yx_reg <= qvr_pkg::prod1_t'(in_data.quat_y) * qvr_pkg::prod1_t'(in_data.pos_x);
        end
    end

    always_comb begin
        tw_next = -qvr_pkg::tval_t'(a_xx_reg) - qvr_pkg::tval_t'(a_yy_reg)
                  - qvr_pkg::tval_t'(a_zz_reg);
        tx_next = qvr_pkg::tval_t'(a_wx_reg) + qvr_pkg::tval_t'(a_yz_reg)
                  - qvr_pkg::tval_t'(a_zy_reg);
        ty_next = qvr_pkg::tval_t'(a_wy_reg) + qvr_pkg::tval_t'(a_zx_reg)
                  - qvr_pkg::tval_t'(a_xz_reg);
        tz_next = qvr_pkg::tval_t'(a_wz_reg) + qvr_pkg::tval_t'(a_xy_reg)
                  - qvr_pkg::tval_t'(a_yx_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            q2x_reg <= q1x_reg;
            q2y_reg <= q1y_reg;
            q2z_reg <= q1z_reg;
            q2w_reg <= q1w_reg;
            tw_reg  <= tw_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            tz_reg  <= tz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            bx0_reg <= qvr_pkg::prod2_t'(tx_reg) * qvr_pkg::prod2_t'(q2w_reg);
            bx1_reg <= qvr_pkg::prod2_t'(tw_reg) * qvr_pkg::prod2_t'(q2x_reg);
            bx2_reg <= qvr_pkg::prod2_t'(ty_reg) * qvr_pkg::prod2_t'(q2z_reg);
            bx3_reg <= qvr_pkg::prod2_t'(tz_reg) * qvr_pkg::prod2_t'(q2y_reg);
            by0_reg <= qvr_pkg::prod2_t'(ty_reg) * qvr_pkg::prod2_t'(q2w_reg);
            by1_reg <= qvr_pkg::prod2_t'(tw_reg) * qvr_pkg::prod2_t'(q2y_reg);
            by2_reg <= qvr_pkg::prod2_t'(tz_reg) * qvr_pkg::prod2_t'(q2x_reg);
            by3_reg <= qvr_pkg::prod2_t'(tx_reg) * qvr_pkg::prod2_t'(q2z_reg);
            bz0_reg <= qvr_pkg::prod2_t'(tz_reg) * qvr_pkg::prod2_t'(q2w_reg);
            bz1_reg <= qvr_pkg::prod2_t'(tw_reg) * qvr_pkg::prod2_t'(q2z_reg);
            bz2_reg <= qvr_pkg::prod2_t'(tx_reg) * qvr_pkg::prod2_t'(q2y_reg);
            bz3_reg <= qvr_pkg::prod2_t'(ty_reg) * qvr_pkg::prod2_t'(q2x_reg);
        end
    end

    always_comb begin
        sx_next = qvr_pkg::sval_t'(bx0_reg) - qvr_pkg::sval_t'(bx1_reg)
                  - qvr_pkg::sval_t'(bx2_reg) + qvr_pkg::sval_t'(bx3_reg);
        sy_next = qvr_pkg::sval_t'(by0_reg) - qvr_pkg::sval_t'(by1_reg)
                  - qvr_pkg::sval_t'(by2_reg) + qvr_pkg::sval_t'(by3_reg);
        sz_next = qvr_pkg::sval_t'(bz0_reg) - qvr_pkg::sval_t'(bz1_reg)
                  - qvr_pkg::sval_t'(bz2_reg) + qvr_pkg::sval_t'(bz3_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    always_comb begin
        cx = qvr_pkg::clamp_pos(qvr_pkg::round_s(sx_reg));
        cy = qvr_pkg::clamp_pos(qvr_pkg::round_s(sy_reg));
        cz = qvr_pkg::clamp_pos(qvr_pkg::round_s(sz_reg));
        out_next.rot_x     = cx[qvr_pkg::POS_W-1:0];
        out_next.rot_y     = cy[qvr_pkg::POS_W-1:0];
        out_next.rot_z     = cz[qvr_pkg::POS_W-1:0];
        out_next.saturated = cx[qvr_pkg::POS_W] | cy[qvr_pkg::POS_W] | cz[qvr_pkg::POS_W];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[qvr_pkg::STAGES-1];
    assign out_data  = out_reg;

    // a stall freezes every valid bit
    `QVR_ASSERT(a_stall_holds, !ctrl.advance |=> $stable(vld_reg),
        "valid bits moved in stall")
    // nothing enters the pipe that was not offered
    `QVR_ASSERT(a_no_phantom,
        $rose(vld_reg[0]) |-> $past(ctrl.in_valid && ctrl.advance),
        "phantom beat")

endmodule

FILE: sv/quaternion_vector_rotator.sv
// ---------------------------------------------------------------------------
// quaternion_vector_rotator
// Rotates a fixed-point 3D position by an unnormalized quaternion.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one beat per item: quaternion x/y/z/w in signed Q2.14
//   and a position x/y/z in signed 24-bit with 8 fraction bits.
//   m_* channel returns one beat per item: q * p * conj(q), vector part,
//   rounded to 8 fraction bits (ties toward +inf) and saturated to 24 bits;
//   saturated is set when any component was clamped.
//   A non-unit quaternion scales the result by |q|^2.
// Output: the result sits in the fifth register stage, whose valid bit
//   drives m_valid.
// Throughput: one beat per cycle while the output is not stalled; the five-stage
//   multiply/add pipeline, not a shared unit, sets this rate.
// Stall: when m_valid is high and m_ready low the whole pipe holds and
//   s_ready drops (s_ready follows m_ready combinationally). Empty slots
//   inside the pipe stay where they are. No beat is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipe; m_valid is low
//   on the first cycle after reset. Beats in flight are discarded.
// ---------------------------------------------------------------------------
`include "quaternion_vector_rotator_defines.svh"

module quaternion_vector_rotator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qvr_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qvr_pkg::out_beat_t  m_data
);

    qvr_pkg::pipe_ctrl_t ctrl;

    // Pipe moves whenever the output register is free or being drained.
    always_comb begin
        ctrl.advance  = !m_valid || m_ready;
        ctrl.in_valid = s_valid;
    end

    assign s_ready = ctrl.advance;

    qvr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_data   (s_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // reset leaves no result pending
    `QVR_ASSERT_ALWAYS(a_reset_empty, $rose(aresetn) |-> !m_valid, "result after reset")
    // a clamp flag always comes with a rail value
    `QVR_ASSERT(a_sat_rail,
        m_valid && m_data.saturated |->
            (m_data.rot_x == qvr_pkg::POS_MAX || m_data.rot_x == qvr_pkg::POS_MIN ||
             m_data.rot_y == qvr_pkg::POS_MAX || m_data.rot_y == qvr_pkg::POS_MIN ||
             m_data.rot_z == qvr_pkg::POS_MAX || m_data.rot_z == qvr_pkg::POS_MIN),
        "flag without rail")

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_vector_rotator. Directed beats cover the
// identity and zero quaternions, axis turns, rounding ties, field extremes and
// clamping. A long random stream then runs with bursty input and a receiver
// that stalls in its own pattern. A shadow rotation predicts every output
// beat, and each output beat is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_BEATS = 900;
    localparam int  HOLD_CYCLES  = 400;    // long m_ready hold-off
    localparam int  TAIL_CYCLES  = 20;     // settle time after the last result
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  Q_ONE        = 16384;  // 1.0 in Q2.14
    localparam int  Q_COS45      = 11585;  // cos(45 deg) in Q2.14

    // Receiver stall patterns, picked per run.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_ALTERNATE
    } ready_mode_e;

    // Shapes of random input beats.
    typedef enum int {
        MIX_RAW,
        MIX_UNIT_Q,
        MIX_SHORT_POS,
        MIX_MID
    } beat_mix_e;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    qvr_pkg::in_beat_t   s_data;
    logic                m_valid;
    logic                m_ready;
    qvr_pkg::out_beat_t  m_data;

    qvr_pkg::out_beat_t  expected_rotations[$];  // predicted outputs, oldest first
    int         error_count  = 0;
    int         results_seen = 0;
    int         cycle_count  = 0;
    int         hold_request = 0;       // set by a test, consumed by the receiver

    quaternion_vector_rotator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Shadow model
    // -----------------------------------------------------------------------

    // Drop 28 fraction bits, ties toward +inf, then clamp to the 24-bit range.
    // An arithmetic shift of the half-biased sum is floor(x + 0.5).
    function automatic qvr_pkg::pos_t round_clamp(input longint acc, inout logic clamped);
        longint r;
        r = (acc + (64'sd1 <<< 27)) >>> 28;
        if (r > longint'(qvr_pkg::POS_MAX)) begin
            clamped = 1'b1;
            return qvr_pkg::POS_MAX;
        end
        if (r < longint'(qvr_pkg::POS_MIN)) begin
            clamped = 1'b1;
            return qvr_pkg::POS_MIN;
        end
        return qvr_pkg::pos_t'(r);
    endfunction

    // q * (v, 0) * conj(q), vector part. All sums stay exact: |s| < 2^58.
    function automatic qvr_pkg::out_beat_t rotate_point(input qvr_pkg::in_beat_t b);
        longint qx, qy, qz, qw, vx, vy, vz;
        longint tw, tx, ty, tz;
        logic clamped;
        qvr_pkg::out_beat_t r;
        qx = b.quat_x;
        qy = b.quat_y;
        qz = b.quat_z;
        qw = b.quat_w;
        vx = b.pos_x;
        vy = b.pos_y;
        vz = b.pos_z;
        // first Hamilton product, 22 fraction bits
        tw = -(qx * vx) - qy * vy - qz * vz;
        tx = qw * vx + qy * vz - qz * vy;
        ty = qw * vy + qz * vx - qx * vz;
        tz = qw * vz + qx * vy - qy * vx;
        // times the conjugate, 36 fraction bits; scalar part is not needed
        clamped = 1'b0;
        r.rot_x = round_clamp(tx * qw - tw * qx - ty * qz + tz * qy, clamped);
        r.rot_y = round_clamp(ty * qw - tw * qy - tz * qx + tx * qz, clamped);
        r.rot_z = round_clamp(tz * qw - tw * qz - tx * qy + ty * qx, clamped);
        r.saturated = clamped;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Beat builders
    // -----------------------------------------------------------------------

    function automatic qvr_pkg::in_beat_t make_beat(input int qx, input int qy,
                                                    input int qz, input int qw,
                                                    input int px, input int py,
                                                    input int pz);
        qvr_pkg::in_beat_t b;
        b.quat_x = qvr_pkg::quat_t'(qx);
        b.quat_y = qvr_pkg::quat_t'(qy);
        b.quat_z = qvr_pkg::quat_t'(qz);
        b.quat_w = qvr_pkg::quat_t'(qw);
        b.pos_x  = qvr_pkg::pos_t'(px);
        b.pos_y  = qvr_pkg::pos_t'(py);
        b.pos_z  = qvr_pkg::pos_t'(pz);
        return b;
    endfunction

    function automatic int near_unit_comp();
        return int'($urandom_range(0, 2 * Q_COS45)) - Q_COS45;
    endfunction

    // Raw beats hit every bit; the other shapes keep more results in range
    // so rounding is exercised away from the clamp.
    function automatic qvr_pkg::in_beat_t random_beat();
        qvr_pkg::in_beat_t b;
        beat_mix_e         mix;
        mix = beat_mix_e'($urandom_range(0, 3));
        b.quat_x = qvr_pkg::quat_t'($urandom);
        b.quat_y = qvr_pkg::quat_t'($urandom);
        b.quat_z = qvr_pkg::quat_t'($urandom);
        b.quat_w = qvr_pkg::quat_t'($urandom);
        b.pos_x  = qvr_pkg::pos_t'($urandom);
        b.pos_y  = qvr_pkg::pos_t'($urandom);
        b.pos_z  = qvr_pkg::pos_t'($urandom);
        case (mix)
            MIX_RAW: begin
            end
            MIX_UNIT_Q: begin
                b.quat_x = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_y = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_z = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_w = qvr_pkg::quat_t'(near_unit_comp());
            end
            MIX_SHORT_POS: begin
                b.pos_x = qvr_pkg::pos_t'(int'($urandom_range(0, 65535)) - 32768);
                b.pos_y = qvr_pkg::pos_t'(int'($urandom_range(0, 65535)) - 32768);
                b.pos_z = qvr_pkg::pos_t'(int'($urandom_range(0, 65535)) - 32768);
            end
            MIX_MID: begin
                b.quat_x = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_y = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_z = qvr_pkg::quat_t'(near_unit_comp());
                b.quat_w = qvr_pkg::quat_t'(near_unit_comp());
                b.pos_x  = qvr_pkg::pos_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
                b.pos_y  = qvr_pkg::pos_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
                b.pos_z  = qvr_pkg::pos_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            end
        endcase
        return b;
    endfunction

    // -----------------------------------------------------------------------
    // Input driver
    // -----------------------------------------------------------------------

    // Offer one beat from the next falling edge and hold it until taken.
    // Back-to-back calls keep s_valid high with no low glitch in between.
    task automatic send_beat(input qvr_pkg::in_beat_t b);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_rotations.push_back(rotate_point(b));
    endtask

    // Idle the input for the gap given by n; payload is junk while valid is low.
    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_data  <= random_beat();
        end
    endtask

    task automatic wait_drained();
        while (expected_rotations.size() != 0) @(posedge aclk);
    endtask

    // -----------------------------------------------------------------------
    // Output checker: one compare per accepted output beat, oldest first
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    qvr_pkg::out_beat_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_rotations.size() == 0) begin
                report_mismatch($sformatf("output beat %0d with nothing pending",
                                          results_seen));
            end else begin
                want = expected_rotations.pop_front();
                if (m_data.rot_x !== want.rot_x)
                    report_mismatch($sformatf("beat %0d rot_x: got %0d, want %0d",
                                              results_seen, m_data.rot_x, want.rot_x));
                if (m_data.rot_y !== want.rot_y)
                    report_mismatch($sformatf("beat %0d rot_y: got %0d, want %0d",
                                              results_seen, m_data.rot_y, want.rot_y));
                if (m_data.rot_z !== want.rot_z)
                    report_mismatch($sformatf("beat %0d rot_z: got %0d, want %0d",
                                              results_seen, m_data.rot_z, want.rot_z));
                if (m_data.saturated !== want.saturated)
                    report_mismatch($sformatf("beat %0d saturated: got %b, want %b",
                                              results_seen, m_data.saturated,
                                              want.saturated));
            end
            results_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall runs of random shape, plus an on-demand long hold-off
    // -----------------------------------------------------------------------

    initial begin
        int          n;
        int          run;
        int          k;
        ready_mode_e mode;
        m_ready = 1'b0;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                repeat (n) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                mode = ready_mode_e'($urandom_range(0, 3));
                run  = $urandom_range(4, 60);
                for (k = 0; k < run && hold_request == 0; k++) begin
                    @(negedge aclk);
                    case (mode)
                        READY_ALWAYS:    m_ready <= 1'b1;
                        READY_COIN:      m_ready <= 1'($urandom_range(0, 1));
                        READY_SPARSE:    m_ready <= ($urandom_range(0, 3) == 0);
                        READY_ALTERNATE: m_ready <= k[0];
                    endcase
                end
            end
        end
    end

    // Hard stop if the pipe wedges.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Identity and zero quaternions; position extremes pass straight through the identity.
    task automatic test_identity_and_zero();
        send_beat(make_beat(0, 0, 0, Q_ONE, 8388607, -8388608, 0));
        send_beat(make_beat(0, 0, 0, Q_ONE, -8388608, 8388607, 1));
        send_beat(make_beat(0, 0, 0, -Q_ONE, 123, -456, 789));   // -1 rotates the same
        send_beat(make_beat(0, 0, 0, 0, 8388607, 8388607, -8388608));
        idle_gap(1);
    endtask

    // Quarter turns about each axis and a half turn about x.
    task automatic test_axis_turns();
        send_beat(make_beat(Q_COS45, 0, 0, Q_COS45, 1000, 2000, 3000));
        send_beat(make_beat(0, Q_COS45, 0, Q_COS45, 1000, 2000, 3000));
        send_beat(make_beat(0, 0, Q_COS45, Q_COS45, 1000, 2000, 3000));
        send_beat(make_beat(Q_ONE, 0, 0, 0, -70000, 5, 123456));
        idle_gap(1);
    endtask

    // w = 0.5 scales by 0.25, so odd multiples of 2 land exactly on a half.
    // Ties must go up for both signs.
    task automatic test_rounding_ties();
        send_beat(make_beat(0, 0, 0, Q_ONE / 2, 2, -2, 6));
        send_beat(make_beat(0, 0, 0, Q_ONE / 2, -6, 10, -10));
        send_beat(make_beat(0, 0, 0, Q_ONE / 2, 1, -1, 3));
        send_beat(make_beat(0, 0, 0, Q_ONE / 2, -3, 0, 7));
        idle_gap(1);
    endtask

    // Field extremes; most of these clamp high or low.
    task automatic test_extremes_and_clamp();
        send_beat(make_beat(32767, 32767, 32767, 32767, 8388607, 8388607, 8388607));
        send_beat(make_beat(-32768, -32768, -32768, -32768,
                            -8388608, -8388608, -8388608));
        send_beat(make_beat(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608));
        send_beat(make_beat(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607));
        send_beat(make_beat(0, 0, 0, -32768, 8388607, -8388608, 1));  // |q|^2 = 4
        send_beat(make_beat(0, 0, 0, 32767, 4, -4, 2097151));          // just in range
        idle_gap(1);
    endtask

    // Output held off long enough for the pipe to fill and push back on the
    // input, then the sender waits for a full drain before moving on.
    task automatic test_backpressure();
        int k;
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 48; k++) send_beat(random_beat());
        idle_gap(1);
        wait_drained();
        for (k = 0; k < 16; k++) send_beat(random_beat());
        idle_gap(1);
    endtask

    // Main stream: bursts of random length, gaps of random length, some of
    // them zero and some bursts long enough to run without idling.
    task automatic test_random_stream(input int count);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 96)
                                                 : $urandom_range(1, 12);
            for (k = 0; k < burst && sent < count; k++) begin
                send_beat(random_beat());
                sent++;
            end
            idle_gap($urandom_range(0, 10));
        end
        idle_gap(1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_identity_and_zero();
        test_axis_turns();
        test_rounding_ties();
        test_extremes_and_clamp();
        test_backpressure();
        test_random_stream(RANDOM_BEATS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
